### design/lqrgs_pkg.sv
// Package for the LQR gain schedule: coefficient table, microcode format and program.
package lqrgs_pkg;

  // Gain matrix shape and mode codes
  localparam int NUM_GAINS   = 12;
  localparam int STAND_GAINS = 8;
  localparam int NUM_ROWS    = 20;   // stand-up rows 0..7, free rows 8..19
  localparam logic [3:0] LAST_GAIN  = 4'd11;
  localparam logic [3:0] ROW1_COL0  = 4'd6;
  localparam logic [3:0] ROW1_COL1  = 4'd7;
  localparam logic [4:0] FREE_BASE  = 5'd8;

  localparam logic [1:0] MODE_STAND = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_HOLD  = 2'd2;

  // Powers of leg length are kept below or at 2^24
  localparam int T_W = 25;
  localparam logic [T_W-1:0] POW_MAX = 25'h100_0000;

  // Cubic coefficients in units of 1e-4: {c3, c2, c1, c0}
  localparam int COEF_RAW [NUM_ROWS][4] = '{
    '{-1985526, 2405928, -1228236, -60633},
    '{2905, 5795, -84417, -3246},
    '{-186488, 229639, -103291, -13522},
    '{-121718, 170661, -92703, -26949},
    '{-699934, 1262554, -876682, 284210},
    '{-209971, 288769, -163728, 49776},
    '{1418965, -750062, -330022, 367073},
    '{132390, -126443, 26696, 26246},
    '{-498019, 1290930, -1042663, 12802},
    '{189768, -155600, -34158, 1196},
    '{-87353, 251947, -179838, 8085},
    '{-80550, 248828, -187111, 6119},
    '{4014921, -3074983, 145249, 362099},
    '{125739, -69702, -43708, 41889},
    '{14785027, -13613845, 2993170, 594659},
    '{1123038, -1331143, 503704, 12789},
    '{2662529, -2037179, 107515, 225716},
    '{1534088, -853909, -338792, 299701},
    '{10399078, -21771517, 13967532, -860345},
    '{862313, -1785719, 1178528, -131555}
  };

  // Microcode control word fields
  typedef enum logic [1:0] {WT_NONE, WT_IN, WT_EMIT} wait_e;
  typedef enum logic [1:0] {JC_NONE, JC_ALWAYS, JC_DONE} jcond_e;
  typedef enum logic [0:0] {MA_T1, MA_COEF} mula_e;
  typedef enum logic [1:0] {MB_T1, MB_T2, MB_T3} mulb_e;
  typedef enum logic [1:0] {CF_C1, CF_C2, CF_C3} coef_e;
  typedef enum logic [1:0] {PW_NONE, PW_T2, PW_T3} poww_e;
  typedef enum logic [1:0] {AC_NONE, AC_INIT, AC_ADD} accop_e;

  typedef struct packed {
    wait_e      wt;
    jcond_e     jc;
    logic [3:0] target;
    mula_e      ma;
    mulb_e      mb;
    coef_e      cf;
    poww_e      pw;
    accop_e     ac;
    logic       gain_wr;
    logic       idx_clr;
    logic       idx_inc;
    logic       emit;
  } uword_t;

  // Program addresses
  localparam logic [3:0] PC_IDLE  = 4'd0;
  localparam logic [3:0] PC_SQ    = 4'd1;
  localparam logic [3:0] PC_SQ_WR = 4'd2;
  localparam logic [3:0] PC_CU    = 4'd3;
  localparam logic [3:0] PC_CU_WR = 4'd4;
  localparam logic [3:0] PC_GAIN  = 4'd5;
  localparam logic [3:0] PC_MAC2  = 4'd6;
  localparam logic [3:0] PC_MAC3  = 4'd7;
  localparam logic [3:0] PC_WRITE = 4'd8;
  localparam logic [3:0] PC_SETUP = 4'd9;
  localparam logic [3:0] PC_EMIT  = 4'd10;

  localparam uword_t UW_NOP = '{
    wt: WT_NONE, jc: JC_NONE, target: PC_IDLE, ma: MA_T1, mb: MB_T1, cf: CF_C1,
    pw: PW_NONE, ac: AC_NONE, gain_wr: 1'b0, idx_clr: 1'b0, idx_inc: 1'b0, emit: 1'b0
  };

  // Control store: one word per program step
  function automatic uword_t ucode_rom(input logic [3:0] pc);
    uword_t w;
    w = UW_NOP;
    unique case (pc)
      PC_IDLE: begin
        w.wt      = WT_IN;
        w.idx_clr = 1'b1;
      end
      PC_SQ: begin
        w.ma = MA_T1;
        w.mb = MB_T1;
      end
      PC_SQ_WR: w.pw = PW_T2;
      PC_CU: begin
        w.ma = MA_T1;
        w.mb = MB_T2;
      end
      PC_CU_WR: w.pw = PW_T3;
      PC_GAIN: begin
        w.jc     = JC_DONE;
        w.target = PC_SETUP;
        w.ac     = AC_INIT;
        w.ma     = MA_COEF;
        w.cf     = CF_C1;
        w.mb     = MB_T1;
      end
      PC_MAC2: begin
        w.ac = AC_ADD;
        w.ma = MA_COEF;
        w.cf = CF_C2;
        w.mb = MB_T2;
      end
      PC_MAC3: begin
        w.ac = AC_ADD;
        w.ma = MA_COEF;
        w.cf = CF_C3;
        w.mb = MB_T3;
      end
      PC_WRITE: begin
        w.gain_wr = 1'b1;
        w.idx_inc = 1'b1;
        w.jc      = JC_ALWAYS;
        w.target  = PC_GAIN;
      end
      PC_SETUP: w.idx_clr = 1'b1;
      PC_EMIT: begin
        w.wt     = WT_EMIT;
        w.emit   = 1'b1;
        w.jc     = JC_ALWAYS;
        w.target = PC_IDLE;
      end
      default: w = UW_NOP;
    endcase
    return w;
  endfunction

endpackage

### design/lqr_gain_schedule_cubic_top.sv
// LQR gain schedule: microcoded evaluation of twelve cubic gains in leg length.
// A transaction accepted at the idle step evaluates N gains, N = 8 in stand-up mode, 12 in free mode,
//   0 in hold mode, on the shared multiplier doing four steps per gain plus four for the powers of leg
//   length. Twelve stored results then leave one per cycle while the output is not stalled.
// Input is taken while the last result waits.
// Reset: gains clear to zero, mode goes to hold, sequencer returns to the idle step.
module lqr_gain_schedule_cubic_top #(
  parameter int LENGTH_FRAC_BITS = 16,
  parameter int GAIN_FRAC_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               balance_mode_we_i,
  input  logic [1:0]         balance_mode_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        leg_length_i,
  input  logic               take_off_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               gain_row_o,
  output logic [2:0]         gain_col_o,
  output logic signed [31:0] gain_value_o,
  output logic               last_o
);

  localparam int TW = lqrgs_pkg::T_W;
  localparam int QW = GAIN_FRAC_BITS + 13;  // coefficient magnitude below 2^(GAIN_FRAC_BITS+12)
  localparam int PW = QW + TW + 1;          // signed product
  localparam int AW = PW + 2;               // sum of four terms
  localparam logic signed [AW-1:0] ACC_HALF = AW'(64'sd1 <<< (LENGTH_FRAC_BITS - 1));
  localparam logic [PW-1:0] POW_HALF = PW'(64'd1 << (LENGTH_FRAC_BITS - 1));
  localparam logic signed [AW-1:0] SAT_MAX = AW'(32'sh7FFF_FFFF);
  localparam logic signed [AW-1:0] SAT_MIN = AW'(32'sh8000_0000);

  // Round a coefficient in units of 1e-4 to the gain format, ties away from zero
  function automatic logic signed [QW-1:0] to_fixed(input int c);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (c < 0) ? 64'(-64'(c)) : 64'(c);
    q = ((mag << GAIN_FRAC_BITS) + 64'd5000) / 64'd10000;
    to_fixed = (c < 0) ? -QW'(q) : QW'(q);
  endfunction

  // Coefficient tables built at elaboration
  logic signed [QW-1:0] coef_c1 [lqrgs_pkg::NUM_ROWS];
  logic signed [QW-1:0] coef_c2 [lqrgs_pkg::NUM_ROWS];
  logic signed [QW-1:0] coef_c3 [lqrgs_pkg::NUM_ROWS];
  logic signed [AW-1:0] init_tab [lqrgs_pkg::NUM_ROWS];

  for (genvar r = 0; r < lqrgs_pkg::NUM_ROWS; r++) begin : g_coef
    assign coef_c3[r]  = to_fixed(lqrgs_pkg::COEF_RAW[r][0]);
    assign coef_c2[r]  = to_fixed(lqrgs_pkg::COEF_RAW[r][1]);
    assign coef_c1[r]  = to_fixed(lqrgs_pkg::COEF_RAW[r][2]);
    assign init_tab[r] = (AW'(to_fixed(lqrgs_pkg::COEF_RAW[r][3])) <<< LENGTH_FRAC_BITS)
                         + ACC_HALF;
  end

  // Sequencer and datapath registers
  logic [3:0]           pc_q, pc_d;
  logic [3:0]           idx_q, idx_d;
  logic [1:0]           mode_q;
  logic [15:0]          t1_q;
  logic                 take_off_q;
  logic [TW-1:0]        t2_q, t3_q;
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic signed [31:0]   store_q [lqrgs_pkg::NUM_GAINS];

  logic                 out_valid_q;
  logic                 gain_row_q;
  logic [2:0]           gain_col_q;
  logic signed [31:0]   gain_value_q;
  logic                 last_q;

  lqrgs_pkg::uword_t    uw;
  logic                 in_acc;
  logic                 out_free;
  logic                 out_load;
  logic                 hold;
  logic                 jump;
  logic [3:0]           gain_cnt;
  logic                 gains_done;
  logic [4:0]           row;
  logic signed [QW-1:0] mul_a;
  logic [TW-1:0]        mul_b;
  logic signed [PW-1:0] prod_d;
  logic [PW-1:0]        pow_sum;
  logic [PW-1:0]        pow_shr;
  logic [TW-1:0]        pow_sat;
  logic signed [AW-1:0] gain_sum;
  logic signed [AW-1:0] gain_shr;
  logic signed [31:0]   gain_sat;
  logic                 zero_frc;
  logic [3:0]           col_full;

  // Decode the current control word
  assign uw = lqrgs_pkg::ucode_rom(pc_q);

  // Handshakes
  assign in_stall_o = (uw.wt != lqrgs_pkg::WT_IN);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = uw.emit && out_free;

  // Gain count for the mode
  always_comb begin
    case (mode_q)
      lqrgs_pkg::MODE_STAND: gain_cnt = 4'(lqrgs_pkg::STAND_GAINS);
      lqrgs_pkg::MODE_FREE:  gain_cnt = 4'(lqrgs_pkg::NUM_GAINS);
      default:               gain_cnt = 4'd0;
    endcase
  end
  assign gains_done = (idx_q == gain_cnt);

  // Step counter: hold on wait, branch, or advance
  always_comb begin
    hold = ((uw.wt == lqrgs_pkg::WT_IN) && !in_acc) ||
           ((uw.wt == lqrgs_pkg::WT_EMIT) && !(out_load && idx_q == lqrgs_pkg::LAST_GAIN));
    jump = (uw.jc == lqrgs_pkg::JC_ALWAYS) ||
           ((uw.jc == lqrgs_pkg::JC_DONE) && gains_done);
    if (hold) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + 4'd1;
    end
  end

  // Gain index
  always_comb begin
    if (uw.idx_clr) begin
      idx_d = 4'd0;
    end else if (uw.idx_inc || out_load) begin
      idx_d = idx_q + 4'd1;
    end else begin
      idx_d = idx_q;
    end
  end

  // Coefficient row for the mode and gain
  assign row = {1'b0, idx_q} + ((mode_q == lqrgs_pkg::MODE_FREE) ? lqrgs_pkg::FREE_BASE : 5'd0);

  // Multiplier operand select
  always_comb begin
    if (uw.ma == lqrgs_pkg::MA_COEF) begin
      case (uw.cf)
        lqrgs_pkg::CF_C2: mul_a = coef_c2[row];
        lqrgs_pkg::CF_C3: mul_a = coef_c3[row];
        default:          mul_a = coef_c1[row];
      endcase
    end else begin
      mul_a = QW'(signed'({1'b0, t1_q}));
    end
    case (uw.mb)
      lqrgs_pkg::MB_T2: mul_b = t2_q;
      lqrgs_pkg::MB_T3: mul_b = t3_q;
      default:          mul_b = TW'(t1_q);
    endcase
  end

  assign prod_d = PW'(mul_a) * PW'(signed'({1'b0, mul_b}));

  // Round and clamp a power of leg length
  assign pow_sum = unsigned'(prod_q) + POW_HALF;
  assign pow_shr = pow_sum >> LENGTH_FRAC_BITS;
  assign pow_sat = (pow_shr > PW'(lqrgs_pkg::POW_MAX)) ? lqrgs_pkg::POW_MAX : pow_shr[TW-1:0];

  // Final term, floor to gain format, saturate
  assign gain_sum = acc_q + AW'(prod_q);
  assign gain_shr = gain_sum >>> LENGTH_FRAC_BITS;
  always_comb begin
    if (gain_shr > SAT_MAX) begin
      gain_sat = 32'sh7FFF_FFFF;
    end else if (gain_shr < SAT_MIN) begin
      gain_sat = 32'sh8000_0000;
    end else begin
      gain_sat = gain_shr[31:0];
    end
  end

  // Airborne in free mode: keep only row 1 columns 0 and 1
  assign zero_frc = (mode_q == lqrgs_pkg::MODE_FREE) && take_off_q &&
                    (idx_q != lqrgs_pkg::ROW1_COL0) && (idx_q != lqrgs_pkg::ROW1_COL1);

  assign col_full = (idx_q >= lqrgs_pkg::ROW1_COL0) ? (idx_q - lqrgs_pkg::ROW1_COL0) : idx_q;

  // Control state, mode register, gain store and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= lqrgs_pkg::PC_IDLE;
      idx_q       <= 4'd0;
      mode_q      <= lqrgs_pkg::MODE_HOLD;
      out_valid_q <= 1'b0;
      for (int i = 0; i < lqrgs_pkg::NUM_GAINS; i++) begin
        store_q[i] <= 32'sd0;
      end
    end else begin
      pc_q  <= pc_d;
      idx_q <= idx_d;
      if (balance_mode_we_i) begin
        mode_q <= balance_mode_i;
      end
      if (uw.gain_wr) begin
        store_q[idx_q] <= zero_frc ? 32'sd0 : gain_sat;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (in_acc) begin
      t1_q       <= leg_length_i;
      take_off_q <= take_off_i;
    end
    if (uw.pw == lqrgs_pkg::PW_T2) begin
      t2_q <= pow_sat;
    end
    if (uw.pw == lqrgs_pkg::PW_T3) begin
      t3_q <= pow_sat;
    end
    case (uw.ac)
      lqrgs_pkg::AC_INIT: acc_q <= init_tab[row];
      lqrgs_pkg::AC_ADD:  acc_q <= acc_q + AW'(prod_q);
      default:            acc_q <= acc_q;
    endcase
    if (out_load) begin
      gain_row_q   <= (idx_q >= lqrgs_pkg::ROW1_COL0);
      gain_col_q   <= col_full[2:0];
      gain_value_q <= store_q[idx_q];
      last_q       <= (idx_q == lqrgs_pkg::LAST_GAIN);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign gain_row_o   = gain_row_q;
  assign gain_col_o   = gain_col_q;
  assign gain_value_o = gain_value_q;
  assign last_o       = last_q;

`ifndef SYNTHESIS
  // Step counter stays inside the program
  assert property (@(posedge clk_i) disable iff (!rst_ni) pc_q <= lqrgs_pkg::PC_EMIT)
    else $error("step counter outside program");

  // Gains are written only below the mode's count
  assert property (@(posedge clk_i) disable iff (!rst_ni) uw.gain_wr |-> (idx_q < gain_cnt))
    else $error("gain write past mode count");

  // A new result appears only from the emit step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(pc_q) == lqrgs_pkg::PC_EMIT))
    else $error("result loaded outside emit step");

  // The final result of a run is row 1 column 5
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |-> (gain_row_q && gain_col_q == 3'd5))
    else $error("last flag on wrong gain");

  // No input is taken while results of the run are still being loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (pc_q == lqrgs_pkg::PC_IDLE && !uw.emit))
    else $error("input accepted mid-run");
`endif

endmodule
